### rtl/nbm_pkg.sv
// Shared types, constants and codes of the NFA byte matcher.
package nbm_pkg;

	localparam int NUM_STATES = 256;
	localparam int SW         = $clog2(NUM_STATES);
	localparam int TAW        = SW + 8;
	localparam int APB_AW     = 3;

	typedef enum logic [2:0] {
		CMD_BYTE   = 3'd0,
		CMD_EPS    = 3'd1,
		CMD_START  = 3'd2,
		CMD_STEP   = 3'd3,
		CMD_FINISH = 3'd4
	} cmd_t;

	typedef enum logic {
		REG_START  = 1'b0,
		REG_ACCEPT = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_POP,
		S_POPW,
		S_EPS,
		S_EPS2,
		S_STEP,
		S_DRAIN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [7:0] start_state;
		logic [7:0] accept_state;
	} cfg_t;

	// true when a stored target names a state that can be entered
	function automatic logic usable(input logic [7:0] t);
		return (t != 8'd0) && ({1'b0, t} < 9'(NUM_STATES));
	endfunction

endpackage

### rtl/nbm_in_if.sv
// Input word channel of the NFA byte matcher.
interface nbm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] state_index;
	logic [7:0] symbol;
	logic [7:0] target;
	logic [7:0] target_alt;

	modport source (output valid, cmd, state_index, symbol, target, target_alt, input ready);
	modport sink (input valid, cmd, state_index, symbol, target, target_alt, output ready);
endinterface

### rtl/nbm_out_if.sv
// Result word channel of the NFA byte matcher.
interface nbm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink (input valid, matched, output ready);
endinterface

### rtl/nbm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module nbm_ram #(
	parameter int W  = 8,
	parameter int D  = 256,
	parameter int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/nbm_cfg.sv
// APB register file holding the start and accept states.
module nbm_cfg
	import nbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t cfg_q;
	reg_t sel;

	assign sel    = reg_t'(paddr[2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				REG_START:  cfg_q.start_state  <= pwdata[7:0];
				REG_ACCEPT: cfg_q.accept_state <= pwdata[7:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_START:  prdata = {24'd0, cfg_q.start_state};
			REG_ACCEPT: prdata = {24'd0, cfg_q.accept_state};
			default:    prdata = 32'd0;
		endcase
	end
endmodule

### rtl/nfa_byte_matcher.sv
// Top level of the NFA byte matcher: command sequencer, set vectors and tables.
//
// Byte-wise Thompson NFA matcher. After reset the block sweeps all NUM_STATES*256
// entries (65536 at 256 states) of the byte transition table to zero, one entry a
// cycle; no word is accepted meanwhile, configuration writes are taken as ever.
// Table write and start words are done in the cycle that accepts them. A
// consume-byte word runs these steps: the accepting cycle, one scan over all
// NUM_STATES states loads the closure stack, each closure state costs a stack read,
// an epsilon table read and two pushes, a check finds the stack empty, a second
// scan reads the byte table once per closed state, and a last step folds in the
// last byte table read. A finish word takes the accepting cycle, scan, walk, empty
// check and result cycle, and leaves one result word in an output register, so the
// next word is taken while the result waits; the result cycle holds while an
// earlier result word is still waiting. Words are worked on one at a time.
module nfa_byte_matcher
	import nbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	nbm_in_if.sink            in_ch,
	nbm_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	cfg_t cfg;

	state_t state_q, state_d;

	logic [TAW-1:0]        clr_q;
	logic [SW-1:0]         cnt_q;
	logic [SW:0]           top_q;
	logic [2:0]            cmd_q;
	logic [7:0]            sym_q;
	logic [NUM_STATES-1:0] active_q;
	logic [NUM_STATES-1:0] visited_q;
	logic [NUM_STATES-1:0] eps_valid_q;
	logic                  eps_vld_s1;
	logic                  pend_s1;
	logic                  out_valid_q;
	logic                  matched_q;

	logic            in_acc;
	logic            idx_ok;
	logic            cnt_last;
	logic [7:0]      eps_t;
	logic            push_ok;
	logic [15:0]     eps_data;
	logic [NUM_STATES-1:0] start_vec;

	logic            tbl_we, tbl_re;
	logic [TAW-1:0]  tbl_waddr, tbl_raddr;
	logic [7:0]      tbl_wdata, tbl_rdata;
	logic            eps_we, eps_re;
	logic [SW-1:0]   eps_waddr, eps_raddr;
	logic [15:0]     eps_wdata, eps_rdata;
	logic            stk_we, stk_re;
	logic [SW-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	nbm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nbm_ram #(.W(8), .D(NUM_STATES * 256)) u_tbl (
		.clk (clk), .we (tbl_we), .waddr (tbl_waddr), .wdata (tbl_wdata),
		.re (tbl_re), .raddr (tbl_raddr), .rdata (tbl_rdata)
	);

	nbm_ram #(.W(16), .D(NUM_STATES)) u_eps (
		.clk (clk), .we (eps_we), .waddr (eps_waddr), .wdata (eps_wdata),
		.re (eps_re), .raddr (eps_raddr), .rdata (eps_rdata)
	);

	nbm_ram #(.W(SW), .D(NUM_STATES)) u_stk (
		.clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
		.re (stk_re), .raddr (stk_raddr), .rdata (stk_rdata)
	);

	assign in_ch.ready    = (state_q == S_IDLE);
	assign in_acc         = in_ch.valid && in_ch.ready;
	assign idx_ok         = {1'b0, in_ch.state_index} < 9'(NUM_STATES);
	assign cnt_last       = (cnt_q == SW'(NUM_STATES - 1));
	assign out_ch.valid   = out_valid_q;
	assign out_ch.matched = matched_q;

	// active set after a start word: only the start state, or empty when out of range
	assign start_vec = ({1'b0, cfg.start_state} < 9'(NUM_STATES)) ?
		(NUM_STATES'(1) << cfg.start_state[SW-1:0]) : '0;

	// unwritten epsilon entries read as no transition
	assign eps_data = eps_rdata & {16{eps_vld_s1}};
	assign eps_t    = (state_q == S_EPS) ? eps_data[7:0] : eps_data[15:8];
	assign push_ok  = usable(eps_t) && !visited_q[eps_t[SW-1:0]];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (in_acc && (in_ch.cmd == CMD_STEP || in_ch.cmd == CMD_FINISH)) begin
					state_d = S_INIT;
				end
			end
			S_INIT: if (cnt_last) state_d = S_POP;
			S_POP: begin
				if (top_q != '0) begin
					state_d = S_POPW;
				end else if (cmd_q == CMD_FINISH) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_STEP;
				end
			end
			S_POPW:  state_d = S_EPS;
			S_EPS:   state_d = S_EPS2;
			S_EPS2:  state_d = S_POP;
			S_STEP:  if (cnt_last) state_d = S_DRAIN;
			S_DRAIN: state_d = S_IDLE;
			S_RESULT: if (!out_valid_q || out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = clr_q;
		tbl_wdata = 8'd0;
		tbl_re    = 1'b0;
		tbl_raddr = {cnt_q, sym_q};
		eps_we    = 1'b0;
		eps_waddr = in_ch.state_index[SW-1:0];
		eps_wdata = {in_ch.target_alt, in_ch.target};
		eps_re    = 1'b0;
		eps_raddr = stk_rdata;
		stk_we    = 1'b0;
		stk_waddr = top_q[SW-1:0];
		stk_wdata = cnt_q;
		stk_re    = 1'b0;
		stk_raddr = SW'(top_q - 1'b1);
		unique case (state_q)
			S_CLEAR: tbl_we = 1'b1;
			S_IDLE: begin
				if (in_acc && idx_ok) begin
					tbl_we    = (in_ch.cmd == CMD_BYTE);
					tbl_waddr = {in_ch.state_index[SW-1:0], in_ch.symbol};
					tbl_wdata = in_ch.target;
					eps_we    = (in_ch.cmd == CMD_EPS);
				end
			end
			S_INIT: stk_we = active_q[cnt_q];
			S_POP:  stk_re = (top_q != '0);
			S_POPW: eps_re = 1'b1;
			S_EPS, S_EPS2: begin
				stk_we    = push_ok;
				stk_wdata = eps_t[SW-1:0];
			end
			S_STEP: tbl_re = visited_q[cnt_q];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			top_q       <= '0;
			cmd_q       <= '0;
			sym_q       <= '0;
			active_q    <= '0;
			visited_q   <= '0;
			eps_valid_q <= '0;
			eps_vld_s1  <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			matched_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// load a result word from a finish walk, else drop the one just taken
			if (state_q == S_RESULT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
				matched_q   <= ({1'b0, cfg.accept_state} < 9'(NUM_STATES)) &&
					visited_q[cfg.accept_state[SW-1:0]];
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= tbl_re;
			// fold the byte table word read last cycle into the new active set
			if (pend_s1 && usable(tbl_rdata)) active_q[tbl_rdata[SW-1:0]] <= 1'b1;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= in_ch.cmd;
						sym_q <= in_ch.symbol;
						cnt_q <= '0;
						if (in_ch.cmd == CMD_EPS && idx_ok) begin
							eps_valid_q[in_ch.state_index[SW-1:0]] <= 1'b1;
						end
						if (in_ch.cmd == CMD_START) begin
							active_q <= start_vec;
						end
					end
				end
				S_INIT: begin
					// seed the closure with the active set
					visited_q[cnt_q] <= active_q[cnt_q];
					if (active_q[cnt_q]) top_q <= top_q + 1'b1;
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
				end
				S_POP: begin
					if (top_q != '0) begin
						top_q <= top_q - 1'b1;
					end else if (cmd_q != CMD_FINISH) begin
						active_q <= '0;
					end
				end
				S_POPW: eps_vld_s1 <= eps_valid_q[stk_rdata];
				S_EPS, S_EPS2: begin
					if (push_ok) begin
						visited_q[eps_t[SW-1:0]] <= 1'b1;
						top_q <= top_q + 1'b1;
					end
				end
				S_STEP: cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	// each state is pushed at most once, so the stack never overflows
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= (SW+1)'(NUM_STATES))
		else $error("closure stack overflow");

	// no table read may be left in flight once the sequencer is idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_s1)
		else $error("byte table read pending in idle");

	// the closure walk only ends with an empty stack
	a_walk_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP && (state_d == S_STEP || state_d == S_RESULT)) |-> top_q == '0)
		else $error("closure ended with stack entries");

	// a result word appears only after a finish walk
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESULT)
		else $error("result word without finish");
endmodule

### tb/sv/nbm_tb_if.sv
`timescale 1ns / 1ps
// Constants shared by the NFA byte matcher testbench.
package nbm_tb_pkg;
	localparam int         N_RANDOM     = 556;
	localparam int         N_FAST       = 100;
	localparam longint     CYCLE_LIMIT  = 4000000;
	localparam logic [2:0] CMD_UNUSED_A = 3'd5;
	localparam logic [2:0] CMD_UNUSED_C = 3'd7;
	localparam logic [1:0] EXP_PRED     = 2'd2;
endpackage

### tb/sv/nfa_byte_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the NFA byte matcher: table loads, match runs, APB config.
module nfa_byte_matcher_tb
	import nbm_pkg::*, nbm_tb_pkg::*;
;

	localparam int N_DIR = 47;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata, prdata;

	nbm_in_if  in_ch();
	nbm_out_if out_ch();

	nfa_byte_matcher uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// one stimulus row: an input word, or a register write when cfg_wr is set
	typedef struct packed {
		logic       cfg_wr;
		logic [2:0] cmd;
		logic [7:0] idx;
		logic [7:0] sym;
		logic [7:0] tgt;
		logic [7:0] alt;
		logic [1:0] chk;   // typed match value, or EXP_PRED for the predictor
	} nfa_word_t;

	// predictor state
	logic [7:0]  trans_tbl [0:NUM_STATES*256-1];
	logic [15:0] eps_tbl [0:NUM_STATES-1];
	logic        cur_set [0:NUM_STATES-1];
	logic        closure [0:NUM_STATES-1];
	logic [7:0]  cfg_start, cfg_accept;

	bit     match_q[$];
	bit     mon_exp;
	int     errors = 0;
	int     results_seen = 0;
	int     words_sent = 0;
	longint cycle = 0;
	bit     idle_off = 0;

	function automatic nfa_word_t wd(input logic [2:0] c, input logic [7:0] i, s, t, a,
			input logic [1:0] e);
		nfa_word_t w;
		w = '0;
		w.cmd = c; w.idx = i; w.sym = s; w.tgt = t; w.alt = a; w.chk = e;
		return w;
	endfunction

	function automatic nfa_word_t cf(input reg_t r, input logic [7:0] v);
		nfa_word_t w;
		w = '0;
		w.cfg_wr = 1'b1; w.idx = {7'd0, r}; w.tgt = v; w.chk = EXP_PRED;
		return w;
	endfunction

	nfa_word_t dir_tbl [N_DIR] = '{
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0),       // empty set after reset
		wd(CMD_STEP, 8'd0, 8'h41, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0),
		wd(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 2'd1),       // start equals accept
		wd(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0),       // cleared table empties set
		wd(CMD_UNUSED_A, 8'd1, 8'd2, 8'd3, 8'd4, EXP_PRED),
		wd(CMD_UNUSED_C, 8'd1, 8'd2, 8'd3, 8'd4, EXP_PRED),
		cf(REG_START, 8'd1),
		cf(REG_ACCEPT, 8'd4),
		wd(CMD_BYTE, 8'd1, 8'h61, 8'd2, 8'd0, EXP_PRED),
		wd(CMD_EPS, 8'd2, 8'd0, 8'd3, 8'd0, EXP_PRED),
		wd(CMD_BYTE, 8'd2, 8'h62, 8'd2, 8'd0, EXP_PRED),
		wd(CMD_BYTE, 8'd3, 8'h63, 8'd4, 8'd0, EXP_PRED),
		wd(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'h61, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'h62, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'h62, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'h63, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'h63, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_EPS, 8'd4, 8'd0, 8'd5, 8'd5, EXP_PRED),
		wd(CMD_EPS, 8'd5, 8'd0, 8'd5, 8'd1, EXP_PRED),
		wd(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_BYTE, 8'd1, 8'hFF, 8'd4, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'hFF, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_BYTE, 8'd255, 8'hFF, 8'd255, 8'd0, EXP_PRED),
		wd(CMD_EPS, 8'd255, 8'd0, 8'd0, 8'd4, EXP_PRED),
		wd(CMD_BYTE, 8'd4, 8'd0, 8'd255, 8'd0, EXP_PRED),
		wd(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'hFF, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_BYTE, 8'd1, 8'h61, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'h61, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		cf(REG_START, 8'd0),
		wd(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED),
		wd(CMD_FINISH, 8'd0, 8'd0, 8'd0, 8'd0, EXP_PRED)
	};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard limit on simulation time, covering the table clear and every word with stalls
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bit ok_target(logic [7:0] t);
		return t != 0 && int'(t) < NUM_STATES;
	endfunction

	// fill closure with the epsilon closure of the current set
	function automatic void eps_close();
		int stk[$];
		int c;
		logic [7:0] t;
		for (int s = 0; s < NUM_STATES; s++) begin
			closure[s] = cur_set[s];
			if (cur_set[s]) stk.push_back(s);
		end
		while (stk.size() != 0) begin
			c = stk.pop_back();
			for (int k = 0; k < 2; k++) begin
				t = k == 0 ? eps_tbl[c][7:0] : eps_tbl[c][15:8];
				if (ok_target(t) && !closure[t]) begin
					closure[t] = 1;
					stk.push_back(int'(t));
				end
			end
		end
	endfunction

	// advance the predictor by one word; push the expected match on finish
	function automatic void predict_nfa(nfa_word_t w);
		logic nxt [0:NUM_STATES-1];
		logic [7:0] t;
		case (w.cmd)
			CMD_BYTE: if (int'(w.idx) < NUM_STATES) trans_tbl[{w.idx, w.sym}] = w.tgt;
			CMD_EPS: if (int'(w.idx) < NUM_STATES) eps_tbl[w.idx] = {w.alt, w.tgt};
			CMD_START: begin
				for (int s = 0; s < NUM_STATES; s++) cur_set[s] = 0;
				if (int'(cfg_start) < NUM_STATES) cur_set[cfg_start] = 1;
			end
			CMD_STEP: begin
				eps_close();
				for (int s = 0; s < NUM_STATES; s++) nxt[s] = 0;
				for (int s = 0; s < NUM_STATES; s++)
					if (closure[s]) begin
						t = trans_tbl[s*256 + int'(w.sym)];
						if (ok_target(t)) nxt[t] = 1;
					end
				for (int s = 0; s < NUM_STATES; s++) cur_set[s] = nxt[s];
			end
			CMD_FINISH: begin
				eps_close();
				match_q.push_back(int'(cfg_accept) < NUM_STATES && closure[cfg_accept]);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] rand_state();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
	endfunction

	function automatic nfa_word_t rand_word();
		nfa_word_t w;
		int pick;
		w = '0;
		w.chk = EXP_PRED;
		pick = $urandom_range(0, 99);
		if (pick < 25) w.cmd = CMD_BYTE;
		else if (pick < 40) w.cmd = CMD_EPS;
		else if (pick < 52) w.cmd = CMD_START;
		else if (pick < 80) w.cmd = CMD_STEP;
		else if (pick < 95) w.cmd = CMD_FINISH;
		else w.cmd = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_A : CMD_UNUSED_C;
		w.idx = rand_state();
		w.sym = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		w.tgt = rand_state();
		w.alt = ($urandom_range(0, 1) == 0) ? 8'd0 : rand_state();
		return w;
	endfunction

	task automatic apb_write(input logic [APB_AW-1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (a[2] == REG_ACCEPT) cfg_accept = d[7:0];
		else cfg_start = d[7:0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [APB_AW-1:0] a);
		logic [31:0] exp_rd;
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		exp_rd = {24'd0, (a[2] == REG_ACCEPT) ? cfg_accept : cfg_start};
		if (prdata !== exp_rd) begin
			$error("prdata: expected %0h, actual %0h", exp_rd, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	// drop valid, then hold until no word is in flight and every result arrived
	task automatic wait_quiet();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (match_q.size() != 0 || !in_ch.ready);
	endtask

	task automatic send_word(input nfa_word_t w);
		int gap;
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid       <= 1'b1;
		in_ch.cmd         <= w.cmd;
		in_ch.state_index <= w.idx;
		in_ch.symbol      <= w.sym;
		in_ch.target      <= w.tgt;
		in_ch.target_alt  <= w.alt;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
		predict_nfa(w);
		if (w.cmd == CMD_FINISH && w.chk != EXP_PRED) match_q[match_q.size() - 1] = w.chk[0];
	endtask

	task automatic run_row(input nfa_word_t w);
		if (w.cfg_wr) begin
			wait_quiet();
			apb_write(APB_AW'({w.idx[0], 2'b00}), {24'd0, w.tgt});
			apb_read_check(APB_AW'({w.idx[0], 2'b00}));
		end else begin
			send_word(w);
		end
	endtask

	// result ready with random stall bursts
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!idle_off && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (match_q.size() == 0) begin
				$error("matched: expected no word, actual %0d", out_ch.matched);
				errors++;
			end else begin
				mon_exp = match_q.pop_front();
				if (out_ch.matched !== mon_exp) begin
					$error("matched: expected %0d, actual %0d", mon_exp, out_ch.matched);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.cmd = '0; in_ch.state_index = '0;
		in_ch.symbol = '0; in_ch.target = '0; in_ch.target_alt = '0;
		cfg_start = '0; cfg_accept = '0;
		for (int i = 0; i < NUM_STATES*256; i++) trans_tbl[i] = '0;
		for (int s = 0; s < NUM_STATES; s++) begin
			eps_tbl[s] = '0; cur_set[s] = 0; closure[s] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++) run_row(dir_tbl[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - N_FAST) idle_off = 1'b1;
			if (i % 97 == 96) begin
				run_row(cf(($urandom_range(0, 1) == 0) ? REG_START : REG_ACCEPT,
					8'($urandom_range(0, 15))));
			end
			run_row(rand_word());
		end
		wait_quiet();
		repeat (20) @(posedge clk);

		$display("Covered %0d words (%0d results): reset behavior, table loads, epsilon",
			words_sent, results_seen);
		$display("loops, byte steps, finishes, unused commands and register writes/reads.");
		if (errors == 0 && match_q.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
